// File: src/dwr_pkg.sv
// Package for the draw-without-replacement block.
// Holds the field widths, the pool limit and the control structs that pass
// between the sequencer and the pool store. Used by every other file.
package dwr_pkg;

    localparam int RV_W      = 31;  // random word
    localparam int NUM_W     = 5;   // drawn number and pool entry
    localparam int SIZE_W    = 6;   // pool size and draw counter
    localparam int RT_W      = 6;   // range_top register
    localparam int DC_W      = 5;   // draw_count register
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;
    localparam int NUMBER_MAX = 31; // largest value a drawn number can carry
    localparam int POOL_DEPTH_DEFAULT = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_TOP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COUNT = 1'd1;

    // Input item kinds.
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_DRAW    = 1'b1;

    // Command from the sequencer to the pool store.
    typedef struct packed {
        logic              fill;
        logic              draw;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] pos;
    } pool_cmd_t;

    // Status back from the pool store.
    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] picked;
    } pool_stat_t;

endpackage

// File: src/dwr_if.sv
// Valid/ready channel interfaces for the draw-without-replacement block.
// Depends on dwr_pkg for the field widths.
interface dwr_in_if import dwr_pkg::*;;
    logic            valid;
    logic            ready;
    logic            kind;
    logic [RV_W-1:0] random_value;

    modport source (output valid, output kind, output random_value, input ready);
    modport sink   (input valid, input kind, input random_value, output ready);
endinterface

interface dwr_out_if import dwr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] drawn_number;
    logic             last_of_run;

    modport source (output valid, output drawn_number, output last_of_run, input ready);
    modport sink   (input valid, input drawn_number, input last_of_run, output ready);
endinterface

// File: src/dwr_mod.sv
// Iterative modulo unit: remainder of the random word by the pool size,
// one quotient bit per cycle by restoring division. Depends on dwr_pkg.
module dwr_mod import dwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RV_W-1:0]   dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              busy,
    output logic [SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(RV_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RV_W-1:0]   dvd_reg, dvd_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] div_reg, div_next;
    logic [SIZE_W-1:0] trial;

    // The remainder stays below the divisor, so its top bit is always clear
    // and the shifted value still fits the same width.
    assign trial = {rem_reg[SIZE_W-2:0], dvd_reg[RV_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RV_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RV_W-2:0], 1'b0};
            rem_next = (trial >= div_reg) ? trial - div_reg : trial;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

// File: src/dwr_pool.sv
// Pool store: a single-port-write memory of pool entries with its own sweep
// counter for refilling and for closing the gap after a draw.
// Depends on dwr_pkg for the command and status structs.
module dwr_pool import dwr_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pool_cmd_t  cmd,
    output pool_stat_t stat
);

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW    = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_FILL  = 2'd1;
    localparam logic [1:0] P_SHIFT = 2'd2;

    logic [NUM_W-1:0] mem [POOL_DEPTH];

    logic [1:0]        pst_reg, pst_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              first_reg, first_next;
    logic [NUM_W-1:0]  picked_reg, picked_next;
    logic [NUM_W-1:0]  rd_data_reg;

    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [NUM_W-1:0]  wr_data;
    logic [CW-1:0]     cnt_inc;

    assign cnt_inc = cnt_reg + CW'(1);

    always_comb
    begin
        pst_next    = pst_reg;
        cnt_next    = cnt_reg;
        size_next   = size_reg;
        first_next  = first_reg;
        picked_next = picked_reg;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[IDX_W-1:0];
        wr_data     = cnt_inc[NUM_W-1:0];
        rd_en       = 1'b0;
        rd_addr     = IDX_W'(cmd.pos);
        unique case (pst_reg)
            P_IDLE:
            begin
                if (cmd.fill)
                begin
                    cnt_next  = '0;
                    size_next = cmd.size;
                    pst_next  = P_FILL;
                end
                else if (cmd.draw)
                begin
                    // The picked entry is read here and lands in the first
                    // cycle of the sweep.
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(cmd.pos);
                    cnt_next   = CW'(cmd.pos);
                    size_next  = cmd.size;
                    first_next = 1'b1;
                    pst_next   = P_SHIFT;
                end
            end
            P_FILL:
            begin
                if (cnt_reg < CW'(size_reg))
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_inc;
                end
                else
                begin
                    pst_next = P_IDLE;
                end
            end
            P_SHIFT:
            begin
                // rd_data_reg: entry cnt_reg; pick first, then each moves one down.
                if (first_reg)
                begin
                    picked_next = rd_data_reg;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[IDX_W-1:0] - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                first_next = 1'b0;
                if (cnt_inc < CW'(size_reg))
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cnt_inc[IDX_W-1:0];
                    cnt_next = cnt_inc;
                end
                else
                begin
                    pst_next = P_IDLE;
                end
            end
            default:
            begin
                pst_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pst_reg <= P_IDLE;
        end
        else
        begin
            pst_reg <= pst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        size_reg   <= size_next;
        first_reg  <= first_next;
        picked_reg <= picked_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.busy   = (pst_reg != P_IDLE);
    assign stat.picked = picked_reg;

endmodule

// File: src/draw_without_replacement.sv
// Random sampling without replacement from a pool of 1 .. range_top-1, at most
// POOL_DEPTH and 31 numbers. A restart refills the pool with a sweep over its
// entries. A draw that yields a number runs the bit-serial modulo unit, then
// moves every entry after the picked position one place down, through the
// single write port of the pool memory. A draw that yields nothing leaves the
// block idle. The block takes one item at a time; the result sits in an output
// register, so the next item may be accepted while it waits to be transferred.
// Pool entries need no clearing after reset.
module draw_without_replacement import dwr_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dwr_in_if.sink               item,
    dwr_out_if.source            result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data
);

    localparam int CAP = (POOL_DEPTH < NUMBER_MAX) ? POOL_DEPTH : NUMBER_MAX;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_DRAW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [RT_W-1:0]   range_top_reg;
    logic [DC_W-1:0]   draw_count_reg;
    logic [SIZE_W-1:0] pool_size_reg, pool_size_next;
    logic [SIZE_W-1:0] draws_done_reg, draws_done_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]  out_num_reg, out_num_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              can_draw;
    logic [SIZE_W-1:0] fill_size;
    logic              mod_start, mod_busy;
    logic [SIZE_W-1:0] mod_rem;
    pool_cmd_t         pcmd;
    pool_stat_t        pstat;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (range_top_reg > RT_W'(1))
        begin
            fill_size = SIZE_W'(range_top_reg - RT_W'(1));
        end
        else
        begin
            fill_size = '0;
        end
        if (fill_size > SIZE_W'(CAP))
        begin
            fill_size = SIZE_W'(CAP);
        end
    end

    assign can_draw = (pool_size_reg != '0) &&
                      (draws_done_reg < SIZE_W'(draw_count_reg));

    assign mod_start = accept && (item.kind == KIND_DRAW) && can_draw;

    dwr_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item.random_value),
        .divisor   (pool_size_reg),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_comb
    begin
        pcmd.fill = accept && (item.kind == KIND_RESTART);
        pcmd.draw = (state_reg == S_MOD) && !mod_busy;
        pcmd.size = pcmd.fill ? fill_size : pool_size_reg;
        pcmd.pos  = mod_rem;
    end

    dwr_pool #(.POOL_DEPTH(POOL_DEPTH)) u_pool
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pcmd),
        .stat  (pstat)
    );

    always_comb
    begin
        state_next      = state_reg;
        pool_size_next  = pool_size_reg;
        draws_done_next = draws_done_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_num_next    = out_num_reg;
        out_last_next   = out_last_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == KIND_RESTART)
                    begin
                        pool_size_next  = fill_size;
                        draws_done_next = '0;
                        state_next      = S_FILL;
                    end
                    else if (can_draw)
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_FILL:
            begin
                if (!pstat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (!pstat.busy)
                begin
                    pool_size_next  = pool_size_reg - SIZE_W'(1);
                    draws_done_next = draws_done_reg + SIZE_W'(1);
                    last_next       = (pool_size_reg == SIZE_W'(1)) ||
                                      (draws_done_reg + SIZE_W'(1) >=
                                       SIZE_W'(draw_count_reg));
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = pstat.picked;
                    out_last_next  = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            range_top_reg  <= RT_W'(25);
            draw_count_reg <= DC_W'(14);
            pool_size_reg  <= '0;
            draws_done_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_size_reg  <= pool_size_next;
            draws_done_reg <= draws_done_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_RANGE_TOP:  range_top_reg  <= wr_data[RT_W-1:0];
                    REG_DRAW_COUNT: draw_count_reg <= wr_data[DC_W-1:0];
                    default:        range_top_reg  <= range_top_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.drawn_number = out_num_reg;
    assign result.last_of_run  = out_last_reg;

endmodule

// File: verif/dwr_checker.sv
// Checker for draw_without_replacement: watches both channels and the register port,
// predicts each drawn number from its own copy of the pool and compares the results.
// Depends on dwr_pkg and on the channel interfaces in dwr_if.sv.
module dwr_checker import dwr_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dwr_in_if                    item,
    dwr_out_if                   result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output int                   fail_count,
    output int                   outstanding,
    output int                   numbers_checked,
    output int                   runs_closed,
    output int                   restarts_seen,
    output int                   draws_seen
);

    // The pool can never hold more numbers than drawn_number can carry.
    localparam int POOL_CAP = (POOL_DEPTH < NUMBER_MAX) ? POOL_DEPTH : NUMBER_MAX;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             last;
    } drawn_t;

    logic [RT_W-1:0]   range_top_q;
    logic [DC_W-1:0]   draw_limit_q;
    logic [NUM_W-1:0]  pool [POOL_DEPTH];
    logic [SIZE_W-1:0] pool_count;
    logic [SIZE_W-1:0] draws_taken;
    drawn_t            drawn_queue [$];

    task automatic predict_item(input logic kind, input logic [RV_W-1:0] word);
        int     fill;
        int     pos;
        drawn_t want;
        if (kind == KIND_RESTART)
        begin
            fill = (range_top_q > 1) ? int'(range_top_q) - 1 : 0;
            if (fill > POOL_CAP)
                fill = POOL_CAP;
            for (int i = 0; i < fill; i++)
                pool[i] = NUM_W'(i + 1);
            pool_count  = SIZE_W'(fill);
            draws_taken = '0;
            restarts_seen++;
        end
        else
        begin
            draws_seen++;
            // An exhausted run or an empty pool leaves everything as it was.
            if (pool_count != 0 && draws_taken < SIZE_W'(draw_limit_q))
            begin
                pos = int'(word % pool_count);
                want.number = pool[pos];
                for (int i = pos; i + 1 < int'(pool_count); i++)
                    pool[i] = pool[i + 1];
                pool_count  = pool_count - 1'b1;
                draws_taken = draws_taken + 1'b1;
                want.last = (draws_taken >= SIZE_W'(draw_limit_q)) || (pool_count == 0);
                drawn_queue.insert(drawn_queue.size(), want);
            end
        end
    endtask

    task automatic compare_result(input logic [NUM_W-1:0] number, input logic last);
        drawn_t want;
        if (drawn_queue.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual number %0d last %0b",
                     $time, number, last);
            fail_count++;
        end
        else
        begin
            want = drawn_queue.pop_front();
            if (want.number !== number)
            begin
                $display("%0t: drawn_number mismatch, expected %0d actual %0d",
                         $time, want.number, number);
                fail_count++;
            end
            if (want.last !== last)
            begin
                $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                         $time, want.last, last);
                fail_count++;
            end
            numbers_checked++;
            if (want.last)
                runs_closed++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_top_q     = 6'd25;
            draw_limit_q    = 5'd14;
            pool_count      = '0;
            draws_taken     = '0;
            drawn_queue.delete();
            fail_count      = 0;
            numbers_checked = 0;
            runs_closed     = 0;
            restarts_seen   = 0;
            draws_seen      = 0;
            outstanding     <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_RANGE_TOP)
                    range_top_q = wr_data[RT_W-1:0];
                else if (wr_index == REG_DRAW_COUNT)
                    draw_limit_q = wr_data[DC_W-1:0];
            end
            // A result transferred at this edge belongs to an earlier item, so it
            // is compared before the item transferred at the same edge is predicted.
            if (result.valid && result.ready)
                compare_result(result.drawn_number, result.last_of_run);
            if (item.valid && item.ready)
                predict_item(item.kind, item.random_value);
            outstanding <= drawn_queue.size();
        end
    end

endmodule

// File: verif/draw_without_replacement_tb.sv
// Top of the draw_without_replacement testbench: clock, reset, register writes,
// restart and draw stimulus with bursty sending and receiver stalls, and the verdict.
// Depends on dwr_pkg, dwr_if.sv, the block itself and dwr_checker.
module draw_without_replacement_tb import dwr_pkg::*;;

    localparam int QUIET_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 100;

    logic clk = 1'b0;
    logic rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DAT_W-1:0] wr_data;

    int fail_count;
    int outstanding;
    int numbers_checked;
    int runs_closed;
    int restarts_seen;
    int draws_seen;
    int cycle_count = 0;
    int burst_left = 0;

    dwr_in_if  item_ch ();
    dwr_out_if result_ch ();

    draw_without_replacement DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch.sink),
        .result   (result_ch.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    dwr_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .numbers_checked (numbers_checked),
        .runs_closed     (runs_closed),
        .restarts_seen   (restarts_seen),
        .draws_seen      (draws_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("draw_without_replacement test failed");
            $finish;
        end
    end

    // Receiver: no stalls, short frequent stalls and long rare stalls take turns.
    initial
    begin
        int hold_left;
        int tick;
        hold_left = 0;
        tick = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                case ((tick / 3000) % 3)
                    1: if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 4);
                    2: if ($urandom_range(0, 19) == 0) hold_left = $urandom_range(5, 60);
                    default: hold_left = 0;
                endcase
            end
        end
    end

    // Sends one item in bursts separated by random gaps; returns at its transfer edge.
    task automatic send_item(input logic kind, input logic [RV_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.random_value <= word;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Waits until every expected number has come and a restart could have finished.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
            repeat (QUIET_CYCLES) @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // The spare top bit of the draw_count write is random; the block ignores it.
    task automatic set_config(input logic [RT_W-1:0] range_top, input logic [DC_W-1:0] limit);
        wr_en    <= 1'b1;
        wr_index <= REG_RANGE_TOP;
        wr_data  <= range_top;
        @(posedge clk);
        wr_index <= REG_DRAW_COUNT;
        wr_data  <= {1'($urandom_range(0, 1)), limit};
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [RV_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RV_W'($urandom_range(0, 40));
            default: return RV_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic [RT_W-1:0] range_top, input logic [DC_W-1:0] limit);
        int sent;
        int run_len;
        sent = 0;
        set_config(range_top, limit);
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(1'($urandom_range(0, 1)), pick_word());
                sent++;
            end
            else
            begin
                // Half the phases carry on with the pool left by the previous setting.
                if (sent != 0 || $urandom_range(0, 1) == 0)
                begin
                    send_item(KIND_RESTART, RV_W'($urandom));
                    sent++;
                end
                run_len = int'(limit) + $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0)
                    run_len = $urandom_range(0, limit);
                for (int k = 0; k < run_len; k++)
                begin
                    send_item(KIND_DRAW, pick_word());
                    if (k < int'(limit))
                        sent++;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        logic [RT_W-1:0] range_top;
        logic [DC_W-1:0] limit;
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = '0;
        wr_data              = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_RESTART;
        item_ch.random_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a draw before any restart, a full run and one past it, then a short second run.
        send_item(KIND_DRAW, '1);
        send_item(KIND_RESTART, '0);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, '1);
        send_item(KIND_DRAW, RV_W'(22));
        for (int k = 0; k < 12; k++)
            send_item(KIND_DRAW, RV_W'($urandom));
        send_item(KIND_RESTART, '1);
        send_item(KIND_DRAW, 31'h5555_5555);
        send_item(KIND_DRAW, 31'h2AAA_AAAA);
        wait_idle();

        // Ranges too small for any number, then a pool of one.
        set_config(6'd0, 5'd31);
        send_item(KIND_RESTART, '0);
        send_item(KIND_DRAW, '1);
        wait_idle();
        set_config(6'd1, 5'd5);
        send_item(KIND_RESTART, '0);
        send_item(KIND_DRAW, '0);
        wait_idle();
        set_config(6'd2, 5'd31);
        send_item(KIND_RESTART, '0);
        send_item(KIND_DRAW, '1);
        send_item(KIND_DRAW, '1);
        wait_idle();

        // Fixed extremes first, then random settings.
        run_phase(6'd63, 5'd31);
        run_phase(6'd32, 5'd0);
        run_phase(6'd32, 5'd31);
        for (int p = 3; p < PHASE_COUNT; p++)
        begin
            range_top = ($urandom_range(0, 4) == 0) ? RT_W'($urandom_range(0, 63))
                                                    : RT_W'($urandom_range(2, 32));
            limit = ($urandom_range(0, 9) == 0) ? DC_W'(0) : DC_W'($urandom_range(1, 31));
            run_phase(range_top, limit);
        end

        $display("Covered %0d restarts and %0d draw requests over several register settings.",
                 restarts_seen, draws_seen);
        $display("Compared %0d drawn numbers, %0d of them closing a run.",
                 numbers_checked, runs_closed);
        if (fail_count == 0 && outstanding == 0)
            $display("draw_without_replacement test passed");
        else
            $display("draw_without_replacement test failed");
        $finish;
    end

endmodule
